### rtl/x86dec_pkg.sv
// Shared types, codes and opcode classification for the x86 subset decoder.
package x86dec_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_W       = 80;

	localparam logic [2:0] FORM_REGRM   = 3'd0;
	localparam logic [2:0] FORM_IMM_RM  = 3'd1;
	localparam logic [2:0] FORM_IMM_REG = 3'd2;
	localparam logic [2:0] FORM_IMM_ACC = 3'd3;
	localparam logic [2:0] FORM_MEM_ACC = 3'd4;
	localparam logic [2:0] FORM_ACC_MEM = 3'd5;
	localparam logic [2:0] FORM_JUMP    = 3'd6;
	localparam logic [2:0] FORM_UNKNOWN = 3'd7;

	localparam logic [2:0] KIND_MOV  = 3'd0;
	localparam logic [2:0] KIND_ADD  = 3'd1;
	localparam logic [2:0] KIND_SUB  = 3'd2;
	localparam logic [2:0] KIND_CMP  = 3'd3;
	localparam logic [2:0] KIND_JUMP = 3'd4;

	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_UNKNOWN     = 2'd1;
	localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

	localparam logic [2:0] GRP_ADD = 3'd0;
	localparam logic [2:0] GRP_SUB = 3'd5;
	localparam logic [2:0] GRP_CMP = 3'd7;

	typedef struct packed {
		logic [15:0] addr;
		logic [7:0]  opcode;
		logic [7:0]  modrm;
		logic [15:0] disp;
		logic [15:0] imm;
		logic        unknown;
	} rec_t;

	function automatic logic [2:0] form_of(input logic [7:0] op);
		logic [2:0] f;
		f = FORM_UNKNOWN;
		if (op[7:2] == 6'b100010 || op[7:2] == 6'b000000 ||
				op[7:2] == 6'b001010 || op[7:2] == 6'b001110)
			f = FORM_REGRM;
		else if (op[7:1] == 7'b1100011 || op[7:2] == 6'b100000)
			f = FORM_IMM_RM;
		else if (op[7:1] == 7'b1010000)
			f = FORM_MEM_ACC;
		else if (op[7:1] == 7'b0000010 || op[7:1] == 7'b0010110 ||
				op[7:1] == 7'b0011110)
			f = FORM_IMM_ACC;
		else if (op[7:4] == 4'b1011)
			f = FORM_IMM_REG;
		else if (op[7:1] == 7'b1010001)
			f = FORM_ACC_MEM;
		else if (op[7:4] == 4'b0111 || op[7:2] == 6'b111000)
			f = FORM_JUMP;
		return f;
	endfunction

	function automatic logic is_group(input logic [7:0] op);
		return op[7:2] == 6'b100000;
	endfunction

	function automatic logic [1:0] imm_len(input logic [7:0] op);
		logic [1:0] n;
		case (form_of(op))
			FORM_IMM_RM: begin
				if (is_group(op) && op[1])
					n = 2'd1;
				else
					n = op[0] ? 2'd2 : 2'd1;
			end
			FORM_IMM_REG: n = op[3] ? 2'd2 : 2'd1;
			FORM_IMM_ACC: n = op[0] ? 2'd2 : 2'd1;
			default:      n = 2'd0;
		endcase
		return n;
	endfunction

	function automatic logic [1:0] disp_len(input logic [7:0] modrm);
		logic [1:0] n;
		case (modrm[7:6])
			2'd0:    n = (modrm[2:0] == 3'd6) ? 2'd2 : 2'd0;
			2'd1:    n = 2'd1;
			2'd2:    n = 2'd2;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

	function automatic logic [15:0] sext8(input logic [7:0] b);
		return {{8{b[7]}}, b};
	endfunction

endpackage

### rtl/x86dec_front.sv
// Byte collector: phase machine that gathers one instruction and pushes a raw record.
module x86dec_front import x86dec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic [7:0]  code_byte,
	input  logic        queue_full,
	output logic        byte_ready,
	input  logic        cfg_load,
	input  logic [15:0] load_address,
	output logic        push,
	output rec_t        push_rec
);

	localparam logic [2:0] PH_OPCODE = 3'd0;
	localparam logic [2:0] PH_MODRM  = 3'd1;
	localparam logic [2:0] PH_DISP   = 3'd2;
	localparam logic [2:0] PH_IMM    = 3'd3;
	localparam logic [2:0] PH_JUMP   = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic        halted_q, halted_d;
	logic [1:0]  left_q, left_d;
	logic [15:0] pos_q;
	logic [15:0] start_q, start_d;
	logic [7:0]  op_q, op_d;
	logic [7:0]  modrm_q, modrm_d;
	logic [15:0] disp_q, disp_d;
	logic [15:0] imm_q, imm_d;
	logic        take;
	logic        unk_d;
	logic [15:0] pos_inc;
	logic [1:0]  dec;
	logic [2:0]  f;

	assign byte_ready = !queue_full || halted_q;
	assign take       = byte_valid && byte_ready && !halted_q;
	assign pos_inc    = pos_q + 16'd1;
	assign dec        = (left_q != 2'd0) ? left_q - 2'd1 : 2'd0;

	always_comb begin
		phase_d  = phase_q;
		halted_d = halted_q;
		left_d   = left_q;
		start_d  = start_q;
		op_d     = op_q;
		modrm_d  = modrm_q;
		disp_d   = disp_q;
		imm_d    = imm_q;
		unk_d    = 1'b0;
		push     = 1'b0;
		f        = form_of(code_byte);
		if (take) begin
			case (phase_q)
				PH_MODRM: begin
					modrm_d = code_byte;
					if (disp_len(code_byte) != 2'd0) begin
						phase_d = PH_DISP;
						left_d  = disp_len(code_byte);
					end else if (imm_len(op_q) != 2'd0) begin
						phase_d = PH_IMM;
						left_d  = imm_len(op_q);
					end else begin
						phase_d = PH_OPCODE;
						push    = 1'b1;
					end
				end
				PH_DISP: begin
					disp_d = {code_byte, disp_q[15:8]};
					left_d = dec;
					if (dec == 2'd0) begin
						if (form_of(op_q) == FORM_MEM_ACC || form_of(op_q) == FORM_ACC_MEM ||
								imm_len(op_q) == 2'd0) begin
							phase_d = PH_OPCODE;
							push    = 1'b1;
						end else begin
							phase_d = PH_IMM;
							left_d  = imm_len(op_q);
						end
					end
				end
				PH_IMM: begin
					imm_d  = {code_byte, imm_q[15:8]};
					left_d = dec;
					if (dec == 2'd0) begin
						phase_d = PH_OPCODE;
						push    = 1'b1;
					end
				end
				PH_JUMP: begin
					imm_d   = pos_inc + sext8(code_byte);
					phase_d = PH_OPCODE;
					push    = 1'b1;
				end
				default: begin
					start_d = pos_q;
					op_d    = code_byte;
					modrm_d = 8'd0;
					disp_d  = 16'd0;
					imm_d   = 16'd0;
					left_d  = 2'd0;
					phase_d = PH_OPCODE;
					case (f)
						FORM_UNKNOWN: begin
							halted_d = 1'b1;
							unk_d    = 1'b1;
							push     = 1'b1;
						end
						FORM_REGRM, FORM_IMM_RM: phase_d = PH_MODRM;
						FORM_MEM_ACC, FORM_ACC_MEM: begin
							phase_d = PH_DISP;
							left_d  = 2'd2;
						end
						FORM_JUMP: phase_d = PH_JUMP;
						default: begin
							phase_d = PH_IMM;
							left_d  = imm_len(code_byte);
						end
					endcase
				end
			endcase
		end
	end

	assign push_rec = '{addr: start_d, opcode: op_d, modrm: modrm_d, disp: disp_d,
		imm: imm_d, unknown: unk_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPCODE;
			halted_q <= 1'b0;
			left_q   <= 2'd0;
			pos_q    <= 16'd0;
		end else begin
			phase_q  <= phase_d;
			halted_q <= halted_d;
			left_q   <= left_d;
			if (cfg_load)
				pos_q <= load_address;
			else if (take)
				pos_q <= pos_inc;
		end
	end

	always_ff @(posedge clk) begin
		start_q <= start_d;
		op_q    <= op_d;
		modrm_q <= modrm_d;
		disp_q  <= disp_d;
		imm_q   <= imm_d;
	end

`ifndef SYNTHESIS
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q) else $error("halt released without reset");
	a_push_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> take) else $error("record pushed without a byte");
	a_no_push_halted: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !push) else $error("record pushed while halted");
`endif

endmodule

### rtl/x86dec_queue.sv
// Small register queue of raw instruction records between collector and formatter.
module x86dec_queue import x86dec_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	input  logic pop,
	output rec_t head,
	output logic empty,
	output logic full
);

	localparam int PW = $clog2(Depth);
	localparam int CW = $clog2(Depth + 1);
	localparam logic [PW-1:0] LAST = PW'(Depth - 1);

	rec_t          mem_q [Depth];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(Depth));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_rec;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue underflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(Depth)) else $error("queue count out of range");
`endif

endmodule

### rtl/x86dec_back.sv
// Record formatter: decodes a raw record into output fields and holds the output word.
module x86dec_back import x86dec_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  rec_t             head,
	input  logic             empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data
);

	logic [2:0]  f, kind, reg_f, rm_f;
	logic [1:0]  mode, status;
	logic        w, d;
	logic [15:0] disp, val;
	logic [7:0]  op;
	logic        valid_q;
	logic [OUT_W-1:0] data_q;

	assign op = head.opcode;

	always_comb begin
		f      = form_of(op);
		kind   = KIND_MOV;
		status = STATUS_OK;
		w      = op[0];
		d      = 1'b0;
		mode   = 2'd0;
		reg_f  = 3'd0;
		rm_f   = 3'd0;
		disp   = 16'd0;
		val    = 16'd0;
		case (imm_len(op))
			2'd1: begin
				if (f == FORM_IMM_RM && is_group(op) && op[1])
					val = sext8(head.imm[15:8]);
				else
					val = {8'd0, head.imm[15:8]};
			end
			2'd2:    val = head.imm;
			default: val = 16'd0;
		endcase
		if (f == FORM_REGRM || f == FORM_IMM_RM) begin
			mode  = head.modrm[7:6];
			reg_f = head.modrm[5:3];
			rm_f  = head.modrm[2:0];
			if (head.modrm[7:6] == 2'd1)
				disp = sext8(head.disp[15:8]);
			else if (disp_len(head.modrm) == 2'd2)
				disp = head.disp;
		end
		case (f)
			FORM_REGRM: begin
				d = op[1];
				case (op[7:2])
					6'b000000: kind = KIND_ADD;
					6'b001010: kind = KIND_SUB;
					6'b001110: kind = KIND_CMP;
					default:   kind = KIND_MOV;
				endcase
			end
			FORM_IMM_RM: begin
				if (is_group(op)) begin
					case (head.modrm[5:3])
						GRP_ADD: kind = KIND_ADD;
						GRP_SUB: kind = KIND_SUB;
						GRP_CMP: kind = KIND_CMP;
						default: status = STATUS_UNSUPPORTED;
					endcase
				end
			end
			FORM_IMM_REG: begin
				w     = op[3];
				reg_f = op[2:0];
			end
			FORM_IMM_ACC: begin
				case (op[7:1])
					7'b0000010: kind = KIND_ADD;
					7'b0010110: kind = KIND_SUB;
					default:    kind = KIND_CMP;
				endcase
			end
			FORM_MEM_ACC, FORM_ACC_MEM: disp = head.disp;
			FORM_JUMP: begin
				kind = KIND_JUMP;
				w    = 1'b0;
				val  = head.imm;
			end
			default: ;
		endcase
		if (head.unknown) begin
			f      = FORM_REGRM;
			kind   = KIND_MOV;
			status = STATUS_UNKNOWN;
			w      = 1'b0;
			d      = 1'b0;
			mode   = 2'd0;
			reg_f  = 3'd0;
			rm_f   = 3'd0;
			disp   = 16'd0;
			val    = 16'd0;
		end
	end

	assign pop       = !empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!valid_q || out_ready)
			valid_q <= !empty;
	end

	always_ff @(posedge clk) begin
		if (pop)
			data_q <= {6'd0, status, val, disp, rm_f, reg_f, mode, d, w, f, kind, op, head.addr};
	end

endmodule

### rtl/x86_16bit_instruction_decoder.sv
// Top level of the byte-serial x86 subset instruction decoder.
// Takes one code byte per cycle on s_axis and emits one 80-bit decoded record on m_axis for
// each completed MOV/ADD/SUB/CMP or conditional jump/loop. The byte collector accepts a byte
// every cycle as long as its record queue (QueueDepth entries) has room; a formatter drains
// the queue into a registered output word, so a record passes through a queue entry and the
// output register before it reaches m_axis. An unknown opcode yields one record with status 1,
// after which bytes are still accepted but dropped until reset. cfg_data loads the address of
// the next stream byte, and cfg_ready is always high.
module x86_16bit_instruction_decoder import x86dec_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,  // code_byte
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// instr_address, opcode_byte, op_kind, form, word_flag, reg_is_dest, mode, reg_field,
	// rm_field, displacement, value, status, zero padding
	output logic [OUT_W-1:0] m_axis_tdata,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [15:0]      cfg_data       // load_address
);

	logic push, pop, empty, full;
	rec_t push_rec, head;

	assign cfg_ready = 1'b1;

	x86dec_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (s_axis_tvalid),
		.code_byte    (s_axis_tdata),
		.queue_full   (full),
		.byte_ready   (s_axis_tready),
		.cfg_load     (cfg_valid),
		.load_address (cfg_data),
		.push         (push),
		.push_rec     (push_rec)
	);

	x86dec_queue #(.Depth(QueueDepth)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	x86dec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

### dv/testbench.sv
// Self-checking testbench for the byte-serial x86 subset instruction decoder.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import x86dec_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int STALL_CYCLES   = 300;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RANDOM_BYTES   = 240;

	localparam logic [7:0] OPC_ADD_RM  = 8'h00;
	localparam logic [7:0] OPC_SUB_RM  = 8'h28;
	localparam logic [7:0] OPC_CMP_RM  = 8'h38;
	localparam logic [7:0] OPC_ADD_ACC = 8'h04;
	localparam logic [7:0] OPC_SUB_ACC = 8'h2C;
	localparam logic [7:0] OPC_JCXZ    = 8'hE3;
	localparam logic [7:0] OPC_MOV_SEG = 8'h8E;

	typedef enum logic [2:0] {
		AT_OPCODE,
		AT_MODRM,
		AT_DISP,
		AT_IMM,
		AT_OFFSET
	} decode_phase_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] value;
		logic [15:0] displacement;
		logic [2:0]  rm_field;
		logic [2:0]  reg_field;
		logic [1:0]  mode;
		logic        reg_is_dest;
		logic        word_flag;
		logic [2:0]  form;
		logic [2:0]  op_kind;
		logic [7:0]  opcode_byte;
		logic [15:0] instr_address;
	} decoded_t;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [15:0]      cfg_data;

	decode_phase_t dec_phase = AT_OPCODE;
	logic [7:0]    cur_opcode = '0;
	logic [7:0]    cur_modrm = '0;
	logic [15:0]   disp_buf = '0;
	logic [15:0]   imm_buf = '0;
	int unsigned   bytes_pending = 0;
	logic [15:0]   next_addr = '0;
	logic [15:0]   instr_start = '0;
	bit            is_halted = 1'b0;

	decoded_t expected_records[$];
	decoded_t seen;
	decoded_t want;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit stall_request = 1'b0;
	int idle_cycles = 0;
	int blocked_cycles = 0;
	int bytes_sent = 0;
	int records_checked = 0;
	int unsupported_seen = 0;
	int origin_loads = 0;
	int mismatches = 0;

	x86_16bit_instruction_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [2:0] form_for(input logic [7:0] op);
		casez (op)
			8'b100010??, 8'b000000??, 8'b001010??, 8'b001110??: form_for = FORM_REGRM;
			8'b1100011?, 8'b100000??:                           form_for = FORM_IMM_RM;
			8'b1010000?:                                         form_for = FORM_MEM_ACC;
			8'b0000010?, 8'b0010110?, 8'b0011110?:               form_for = FORM_IMM_ACC;
			8'b1011????:                                         form_for = FORM_IMM_REG;
			8'b1010001?:                                         form_for = FORM_ACC_MEM;
			8'b0111????, 8'b111000??:                            form_for = FORM_JUMP;
			default:                                             form_for = FORM_UNKNOWN;
		endcase
	endfunction

	function automatic bit is_arith_group(input logic [7:0] op);
		return op[7:2] == 6'b100000;
	endfunction

	function automatic int unsigned imm_bytes_for(input logic [7:0] op);
		case (form_for(op))
			FORM_IMM_RM:  return (is_arith_group(op) && op[1]) ? 1 : (op[0] ? 2 : 1);
			FORM_IMM_REG: return op[3] ? 2 : 1;
			FORM_IMM_ACC: return op[0] ? 2 : 1;
			default:      return 0;
		endcase
	endfunction

	function automatic int unsigned disp_bytes_for(input logic [7:0] modrm);
		case (modrm[7:6])
			2'd0:    return (modrm[2:0] == 3'd6) ? 2 : 0;
			2'd1:    return 1;
			2'd2:    return 2;
			default: return 0;
		endcase
	endfunction

	function automatic logic [15:0] widen(input logic [7:0] b);
		return {{8{b[7]}}, b};
	endfunction

	task automatic complete_instr();
		decoded_t r;
		logic [2:0] f;
		int unsigned il;
		r = '0;
		f = form_for(cur_opcode);
		il = imm_bytes_for(cur_opcode);
		r.instr_address = instr_start;
		r.opcode_byte = cur_opcode;
		r.form = f;
		r.op_kind = KIND_MOV;
		r.word_flag = cur_opcode[0];
		r.status = STATUS_OK;
		if (il == 1)
			r.value = (is_arith_group(cur_opcode) && cur_opcode[1]) ?
				widen(imm_buf[15:8]) : {8'h00, imm_buf[15:8]};
		else if (il == 2)
			r.value = imm_buf;
		if (f == FORM_REGRM || f == FORM_IMM_RM) begin
			r.mode = cur_modrm[7:6];
			r.reg_field = cur_modrm[5:3];
			r.rm_field = cur_modrm[2:0];
			if (r.mode == 2'd1)
				r.displacement = widen(disp_buf[15:8]);
			else if (disp_bytes_for(cur_modrm) == 2)
				r.displacement = disp_buf;
		end
		if (f == FORM_MEM_ACC || f == FORM_ACC_MEM)
			r.displacement = disp_buf;
		case (f)
			FORM_REGRM: begin
				r.reg_is_dest = cur_opcode[1];
				case ({cur_opcode[7:2], 2'b00})
					OPC_ADD_RM: r.op_kind = KIND_ADD;
					OPC_SUB_RM: r.op_kind = KIND_SUB;
					OPC_CMP_RM: r.op_kind = KIND_CMP;
					default:    r.op_kind = KIND_MOV;
				endcase
			end
			FORM_IMM_RM: begin
				if (is_arith_group(cur_opcode)) begin
					case (r.reg_field)
						GRP_ADD: r.op_kind = KIND_ADD;
						GRP_SUB: r.op_kind = KIND_SUB;
						GRP_CMP: r.op_kind = KIND_CMP;
						default: r.status = STATUS_UNSUPPORTED;
					endcase
				end
			end
			FORM_IMM_REG: begin
				r.word_flag = cur_opcode[3];
				r.reg_field = cur_opcode[2:0];
			end
			FORM_IMM_ACC: begin
				case ({cur_opcode[7:1], 1'b0})
					OPC_ADD_ACC: r.op_kind = KIND_ADD;
					OPC_SUB_ACC: r.op_kind = KIND_SUB;
					default:     r.op_kind = KIND_CMP;
				endcase
			end
			default: ;
		endcase
		dec_phase = AT_OPCODE;
		expected_records.push_back(r);
	endtask

	task automatic after_disp();
		int unsigned il;
		il = imm_bytes_for(cur_opcode);
		if (il != 0) begin
			dec_phase = AT_IMM;
			bytes_pending = il;
		end else begin
			complete_instr();
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		decoded_t r;
		logic [15:0] at;
		logic [2:0] f;
		int unsigned dl;
		if (is_halted)
			return;
		at = next_addr;
		next_addr = next_addr + 16'd1;
		case (dec_phase)
			AT_MODRM: begin
				cur_modrm = b;
				dl = disp_bytes_for(b);
				if (dl != 0) begin
					dec_phase = AT_DISP;
					bytes_pending = dl;
				end else begin
					after_disp();
				end
			end
			AT_DISP: begin
				disp_buf = {b, disp_buf[15:8]};
				if (bytes_pending != 0)
					bytes_pending--;
				if (bytes_pending == 0) begin
					if (form_for(cur_opcode) >= FORM_MEM_ACC)
						complete_instr();
					else
						after_disp();
				end
			end
			AT_IMM: begin
				imm_buf = {b, imm_buf[15:8]};
				if (bytes_pending != 0)
					bytes_pending--;
				if (bytes_pending == 0)
					complete_instr();
			end
			AT_OFFSET: begin
				r = '0;
				r.instr_address = instr_start;
				r.opcode_byte = cur_opcode;
				r.op_kind = KIND_JUMP;
				r.form = FORM_JUMP;
				r.value = next_addr + widen(b);
				r.status = STATUS_OK;
				dec_phase = AT_OPCODE;
				expected_records.push_back(r);
			end
			default: begin
				instr_start = at;
				cur_opcode = b;
				cur_modrm = '0;
				disp_buf = '0;
				imm_buf = '0;
				bytes_pending = 0;
				f = form_for(b);
				case (f)
					FORM_UNKNOWN: begin
						r = '0;
						r.instr_address = at;
						r.opcode_byte = b;
						r.op_kind = KIND_MOV;
						r.form = FORM_REGRM;
						r.status = STATUS_UNKNOWN;
						is_halted = 1'b1;
						dec_phase = AT_OPCODE;
						expected_records.push_back(r);
					end
					FORM_REGRM, FORM_IMM_RM: dec_phase = AT_MODRM;
					FORM_MEM_ACC, FORM_ACC_MEM: begin
						dec_phase = AT_DISP;
						bytes_pending = 2;
					end
					FORM_JUMP: dec_phase = AT_OFFSET;
					default: begin
						dec_phase = AT_IMM;
						bytes_pending = imm_bytes_for(b);
					end
				endcase
			end
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		decode_byte(b);
		bytes_sent++;
	endtask

	task automatic send_stream(input logic [7:0] code[$]);
		foreach (code[i])
			send_byte(code[i]);
	endtask

	task automatic send_instruction(input logic [7:0] op);
		logic [7:0] modrm;
		send_byte(op);
		case (form_for(op))
			FORM_REGRM, FORM_IMM_RM: begin
				modrm = 8'($urandom);
				send_byte(modrm);
				repeat (disp_bytes_for(modrm))
					send_byte(8'($urandom));
			end
			FORM_MEM_ACC, FORM_ACC_MEM: repeat (2) send_byte(8'($urandom));
			FORM_JUMP: send_byte(8'($urandom));
			default: ;
		endcase
		repeat (imm_bytes_for(op))
			send_byte(8'($urandom));
	endtask

	function automatic logic [7:0] pick_opcode();
		logic [7:0] op;
		do
			op = 8'($urandom);
		while (form_for(op) == FORM_UNKNOWN);
		return op;
	endfunction

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_origin(input logic [15:0] addr);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= addr;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		next_addr = addr;
		origin_loads++;
	endtask

	task automatic test_directed();
		tx_idle_pct = 8;
		rx_idle_pct = 58;
		load_origin(16'hFFFF);
		send_stream('{8'h74, 8'h80, 8'h00, 8'hC0, 8'h2B, 8'h46, 8'hFF, 8'h38, 8'h06,
			8'h34, 8'h12, 8'h83, 8'hE8, 8'h80, 8'h80, 8'hD0, 8'h00, 8'hA0, 8'h00,
			8'h80, 8'hA3, 8'hFF, 8'hFF, 8'h3D, 8'h00, 8'h80, 8'hB7, 8'hFF});
		// reload the counter between a JCXZ opcode and its offset
		send_byte(OPC_JCXZ);
		load_origin(16'h7FFF);
		send_byte(8'h7F);
	endtask

	task automatic test_backpressure();
		load_origin(16'h1000);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		stall_request = 1'b1;
		repeat (24)
			send_instruction(pick_opcode());
	endtask

	task automatic test_random(input int tx_pct, input int rx_pct, input logic [15:0] origin);
		int first;
		load_origin(origin);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		first = bytes_sent;
		while (bytes_sent - first < RANDOM_BYTES)
			send_instruction(pick_opcode());
	endtask

	task automatic test_unknown_opcode();
		load_origin(16'h2468);
		tx_idle_pct = 8;
		rx_idle_pct = 8;
		send_instruction(pick_opcode());
		send_byte(OPC_MOV_SEG);
		// halted: everything after this is dropped
		repeat (12)
			send_byte(8'($urandom));
	endtask

	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic check_field(input string name, input logic [15:0] exp_v, input logic [15:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			seen = m_axis_tdata[$bits(decoded_t)-1:0];
			if (expected_records.size() == 0) begin
				$error("record for address 0x%0h with no instruction pending", seen.instr_address);
				mismatches++;
			end else begin
				want = expected_records.pop_front();
				check_field("instr_address", want.instr_address, seen.instr_address);
				check_field("opcode_byte", 16'(want.opcode_byte), 16'(seen.opcode_byte));
				check_field("op_kind", 16'(want.op_kind), 16'(seen.op_kind));
				check_field("form", 16'(want.form), 16'(seen.form));
				check_field("word_flag", 16'(want.word_flag), 16'(seen.word_flag));
				check_field("reg_is_dest", 16'(want.reg_is_dest), 16'(seen.reg_is_dest));
				check_field("mode", 16'(want.mode), 16'(seen.mode));
				check_field("reg_field", 16'(want.reg_field), 16'(seen.reg_field));
				check_field("rm_field", 16'(want.rm_field), 16'(seen.rm_field));
				check_field("displacement", want.displacement, seen.displacement);
				check_field("value", want.value, seen.value);
				check_field("status", 16'(want.status), 16'(seen.status));
				records_checked++;
				if (want.status == STATUS_UNSUPPORTED)
					unsupported_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b0)
			blocked_cycles++;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_random(8, 58, 16'hFFC0);
		test_random(58, 8, 16'($urandom_range(65535)));
		test_random(0, 0, 16'h0000);
		test_unknown_opcode();
		settle();
		if (expected_records.size() != 0) begin
			$error("%0d decoded records never arrived", expected_records.size());
			mismatches++;
		end
		$display("Fed %0d code bytes over %0d load addresses; checked %0d records, %0d unsupported.",
			bytes_sent, origin_loads, records_checked, unsupported_seen);
		$display("Input stalled by a full record queue for %0d cycles; %0d mismatches.",
			blocked_cycles, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### x86_16bit_instruction_decoder.f
rtl/x86dec_pkg.sv
rtl/x86dec_front.sv
rtl/x86dec_queue.sv
rtl/x86dec_back.sv
rtl/x86_16bit_instruction_decoder.sv
dv/testbench.sv
